// File: rtl/core/vertex_directional_lighting_defines.svh
// Assertion macros shared by the vertex lighting RTL.
// Depends on i_clk and i_rst_n being present in the module that uses them.
`ifndef VERTEX_DIRECTIONAL_LIGHTING_DEFINES_SVH
`define VERTEX_DIRECTIONAL_LIGHTING_DEFINES_SVH

// same-cycle implication, checked out of reset
`define VDL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define VDL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/vdl_pkg.sv
// Shared types, constants and helper functions for the vertex lighting block.
// No dependencies.
`timescale 1ns / 1ps

package vdl_pkg;

    localparam int UNIT_ONE   = 4096;
    localparam int UNIT_SHIFT = $clog2(UNIT_ONE);

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int DIR_W  = 48;
    localparam int RGB_W  = 24;

    localparam int Q_W    = 16;
    localparam int INT_W  = Q_W + 2;
    localparam int PROD_W = 8 + INT_W;
    localparam int SCL_W  = PROD_W - UNIT_SHIFT;

    typedef enum logic [2:0] {
        REG_DIR0 = 3'd0,
        REG_DIR1 = 3'd1,
        REG_COL0 = 3'd2,
        REG_COL1 = 3'd3,
        REG_AMB  = 3'd4,
        REG_ENV  = 3'd5
    } t_reg_idx;

    localparam logic [RGB_W-1:0] ENV_RESET = 24'hFF_FFFF;

    typedef struct packed {
        logic [DIR_W-1:0] dir0;
        logic [DIR_W-1:0] dir1;
        logic [RGB_W-1:0] col0;
        logic [RGB_W-1:0] col1;
        logic [RGB_W-1:0] amb;
        logic [RGB_W-1:0] env;
    } t_cfg;

    typedef struct packed {
        logic [7:0] vr;
        logic [7:0] vg;
        logic [7:0] vb;
        logic       lit;
        logic       env;
    } t_side;

    function automatic logic [7:0] scale_sat(input logic [PROD_W-1:0] p);
        logic [SCL_W-1:0] s;
        s = p[PROD_W-1:UNIT_SHIFT];
        return (s > SCL_W'(255)) ? 8'hFF : s[7:0];
    endfunction

    function automatic logic [7:0] add3_sat(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
        logic [9:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c};
        return (s > 10'd255) ? 8'hFF : s[7:0];
    endfunction

endpackage

// File: rtl/core/vdl_cfg.sv
// Configuration register bank with an APB-style slave port.
// Depends on vdl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "vertex_directional_lighting_defines.svh"

module vdl_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vdl_pkg::ADDR_W-1:0]  paddr,
    input  logic [vdl_pkg::DATA_W-1:0]  pwdata,
    output logic [vdl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output vdl_pkg::t_cfg               o_cfg
);
    import vdl_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_DIR0: n_cfg.dir0 = pwdata[DIR_W-1:0];
                REG_DIR1: n_cfg.dir1 = pwdata[DIR_W-1:0];
                REG_COL0: n_cfg.col0 = pwdata[RGB_W-1:0];
                REG_COL1: n_cfg.col1 = pwdata[RGB_W-1:0];
                REG_AMB:  n_cfg.amb  = pwdata[RGB_W-1:0];
                REG_ENV:  n_cfg.env  = pwdata[RGB_W-1:0];
                default:  n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DIR0: prdata = DATA_W'(r_cfg.dir0);
            REG_DIR1: prdata = DATA_W'(r_cfg.dir1);
            REG_COL0: prdata = DATA_W'(r_cfg.col0);
            REG_COL1: prdata = DATA_W'(r_cfg.col1);
            REG_AMB:  prdata = DATA_W'(r_cfg.amb);
            REG_ENV:  prdata = DATA_W'(r_cfg.env);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{dir0: '0, dir1: '0, col0: '0, col1: '0, amb: '0, env: ENV_RESET};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    `VDL_ASSERT_NXT(a_env_wr, w_wr && w_idx == REG_ENV, r_cfg.env == $past(pwdata[RGB_W-1:0]), "environment write lost")
    `VDL_ASSERT_NXT(a_bad_idx, w_wr && paddr[5:3] > 3'd5, $stable(r_cfg), "write beyond register list changed state")

endmodule

// File: rtl/core/vdl_light.sv
// Three-stage datapath for one directional light: axis products, intensity
// sum, color scaling. Depends on vdl_pkg.
`timescale 1ns / 1ps

module vdl_light (
    input  logic                              i_clk,
    input  logic [2:0][7:0]                   i_normal,
    input  logic [vdl_pkg::DIR_W-1:0]         i_dir,
    input  logic [vdl_pkg::RGB_W-1:0]         i_color,
    output logic [2:0][vdl_pkg::PROD_W-1:0]   o_prod
);
    import vdl_pkg::*;

    logic signed [23:0]          w_p [3];
    logic [2:0][Q_W-1:0]         r_q;
    logic [2:0][Q_W-1:0]         n_q;
    logic [INT_W-1:0]            r_int;
    logic [INT_W-1:0]            n_int;
    logic [2:0][PROD_W-1:0]      r_prod;
    logic [2:0][PROD_W-1:0]      n_prod;

    // keep only positive axis terms; for those the shift equals truncation
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_p[k] = $signed(i_normal[k]) * $signed(i_dir[16*k +: 16]);
            n_q[k] = (w_p[k] > 24'sd0) ? w_p[k][22:7] : '0;
        end
    end

    assign n_int = INT_W'(r_q[0]) + INT_W'(r_q[1]) + INT_W'(r_q[2]);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = PROD_W'(i_color[8*k +: 8]) * PROD_W'(r_int);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_int  <= n_int;
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/vertex_directional_lighting.sv
// Vertex lighting top level: register bank, two light pipelines, final mix.
// Depends on vdl_pkg, vdl_cfg, vdl_light and the assertion macro header.
`timescale 1ns / 1ps
`include "vertex_directional_lighting_defines.svh"

// One vertex is taken in every clock cycle (busy stays low) and its color
// appears on the o_out_* ports after the register stages below, for one cycle,
// marked by o_valid. The four register stages are the axis multipliers, the
// intensity adder, the color multipliers and the saturating mix; results
// leave in input order and the receiver must take each one when o_valid is
// high. The user must write registers through the APB-style port only while
// no vertex is in flight; the block itself does not enforce this.

module vertex_directional_lighting (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [7:0]                  i_vertex_r,
    input  logic [7:0]                  i_vertex_g,
    input  logic [7:0]                  i_vertex_b,
    input  logic                        i_lit_flag,
    input  logic                        i_env_flag,
    output logic                        o_valid,
    output logic [7:0]                  o_out_red,
    output logic [7:0]                  o_out_green,
    output logic [7:0]                  o_out_blue,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vdl_pkg::ADDR_W-1:0]  paddr,
    input  logic [vdl_pkg::DATA_W-1:0]  pwdata,
    output logic [vdl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import vdl_pkg::*;

    t_cfg                   w_cfg;
    logic [2:0][7:0]        w_normal;
    logic [2:0][PROD_W-1:0] w_prod0;
    logic [2:0][PROD_W-1:0] w_prod1;
    logic                   w_accept;

    logic                   r_v1, r_v2, r_v3, r_vo;
    t_side                  r_side1, r_side2, r_side3;
    t_side                  n_side1;
    logic [2:0][7:0]        r_rgb;
    logic [2:0][7:0]        n_rgb;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;
    assign w_normal = {i_vertex_b, i_vertex_g, i_vertex_r};

    assign n_side1 = '{vr: i_vertex_r, vg: i_vertex_g, vb: i_vertex_b,
                       lit: i_lit_flag, env: i_env_flag};

    vdl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    vdl_light u_light0 (
        .i_clk    (i_clk),
        .i_normal (w_normal),
        .i_dir    (w_cfg.dir0),
        .i_color  (w_cfg.col0),
        .o_prod   (w_prod0)
    );

    vdl_light u_light1 (
        .i_clk    (i_clk),
        .i_normal (w_normal),
        .i_dir    (w_cfg.dir1),
        .i_color  (w_cfg.col1),
        .o_prod   (w_prod1)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_side3.lit) begin
                n_rgb[k] = add3_sat(w_cfg.amb[8*k +: 8], scale_sat(w_prod0[k]),
                                    scale_sat(w_prod1[k]));
            end else if (r_side3.env) begin
                n_rgb[k] = w_cfg.env[8*k +: 8];
            end else begin
                case (k)
                    0:       n_rgb[k] = r_side3.vr;
                    1:       n_rgb[k] = r_side3.vg;
                    default: n_rgb[k] = r_side3.vb;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side1 <= n_side1;
        r_side2 <= r_side1;
        r_side3 <= r_side2;
        r_rgb   <= n_rgb;
    end

    assign o_valid     = r_vo;
    assign o_out_red   = r_rgb[0];
    assign o_out_green = r_rgb[1];
    assign o_out_blue  = r_rgb[2];

    `VDL_ASSERT_NOW(a_lat, o_valid, $past(w_accept, 4), "result without a transfer four cycles back")
    `VDL_ASSERT_NOW(a_pass, o_valid && $past(!i_lit_flag && !i_env_flag, 4), o_out_red == $past(i_vertex_r, 4) && o_out_blue == $past(i_vertex_b, 4), "unlit vertex color altered")
    `VDL_ASSERT_NOW(a_env, o_valid && $past(!i_lit_flag && i_env_flag, 4), o_out_green == w_cfg.env[15:8], "environment color not selected")

endmodule

// File: tb/vdl_color_checker.sv
// Checker for the vertex lighting block: tracks register writes, predicts each vertex color
// and compares every o_valid result against the oldest outstanding prediction.
// Depends on vdl_pkg for the register layout, index codes and UNIT_ONE.
`timescale 1ns / 1ps

module vdl_color_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [7:0]                    i_vertex_r,
    input  logic [7:0]                    i_vertex_g,
    input  logic [7:0]                    i_vertex_b,
    input  logic                          i_lit_flag,
    input  logic                          i_env_flag,
    input  logic                          i_valid,
    input  logic [7:0]                    i_out_red,
    input  logic [7:0]                    i_out_green,
    input  logic [7:0]                    i_out_blue,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [vdl_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [vdl_pkg::DATA_W-1:0]    i_pwdata,
    input  logic                          i_pready,
    output int                            o_pending,
    output int                            o_errors,
    output int                            o_results
);

    vdl_pkg::t_cfg cfg;
    logic [23:0]   color_q[$];
    string         chan_name[3] = '{"red", "green", "blue"};

    initial begin
        o_pending = 0;
        o_errors  = 0;
        o_results = 0;
    end

    task automatic report(input string msg);
        $display("%0t vdl_color_checker: %s", $time, msg);
        o_errors++;
    endtask

    function automatic logic [23:0] light_share(input logic [47:0] dir, input logic [23:0] col,
                                                input logic [23:0] nrm);
        int          inten;
        int          q;
        int          s;
        int          k;
        logic [23:0] share;
        inten = 0;
        for (k = 0; k < 3; k++) begin
            q = (int'($signed(nrm[8*k +: 8])) * int'($signed(dir[16*k +: 16]))) / 128;
            if (q > 0) inten += q;
        end
        for (k = 0; k < 3; k++) begin
            if (inten <= 0) begin
                share[8*k +: 8] = 8'h00;
            end else begin
                s = (int'(col[8*k +: 8]) * inten) / vdl_pkg::UNIT_ONE;
                share[8*k +: 8] = (s > 255) ? 8'hFF : s[7:0];
            end
        end
        return share;
    endfunction

    function automatic logic [23:0] vertex_color(input vdl_pkg::t_cfg c, input logic [23:0] vtx,
                                                 input logic lit, input logic env);
        logic [23:0] a;
        logic [23:0] b;
        logic [23:0] mix;
        int          s;
        int          k;
        if (lit) begin
            a = light_share(c.dir0, c.col0, vtx);
            b = light_share(c.dir1, c.col1, vtx);
            for (k = 0; k < 3; k++) begin
                s = int'(c.amb[8*k +: 8]) + int'(a[8*k +: 8]) + int'(b[8*k +: 8]);
                mix[8*k +: 8] = (s > 255) ? 8'hFF : s[7:0];
            end
        end else if (env) begin
            mix = c.env;
        end else begin
            mix = vtx;
        end
        return mix;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [23:0] want;
        logic [23:0] got;
        int          k;
        if (!i_rst_n) begin
            cfg      = '0;
            cfg.env  = vdl_pkg::ENV_RESET;
            color_q.delete();
            o_pending <= 0;
        end else begin
            if (i_valid) begin
                if (color_q.size() == 0) begin
                    report("result with no vertex outstanding");
                end else begin
                    want = color_q.pop_front();
                    got  = {i_out_blue, i_out_green, i_out_red};
                    for (k = 0; k < 3; k++) begin
                        if (got[8*k +: 8] !== want[8*k +: 8]) begin
                            report($sformatf("%s got %02h want %02h", chan_name[k],
                                             got[8*k +: 8], want[8*k +: 8]));
                        end
                    end
                    o_results++;
                end
            end
            if (i_start && !i_busy) begin
                color_q.push_back(vertex_color(cfg, {i_vertex_b, i_vertex_g, i_vertex_r},
                                               i_lit_flag, i_env_flag));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (vdl_pkg::t_reg_idx'(i_paddr[vdl_pkg::ADDR_W-1:3]))
                    vdl_pkg::REG_DIR0: cfg.dir0 = i_pwdata[vdl_pkg::DIR_W-1:0];
                    vdl_pkg::REG_DIR1: cfg.dir1 = i_pwdata[vdl_pkg::DIR_W-1:0];
                    vdl_pkg::REG_COL0: cfg.col0 = i_pwdata[vdl_pkg::RGB_W-1:0];
                    vdl_pkg::REG_COL1: cfg.col1 = i_pwdata[vdl_pkg::RGB_W-1:0];
                    vdl_pkg::REG_AMB:  cfg.amb  = i_pwdata[vdl_pkg::RGB_W-1:0];
                    vdl_pkg::REG_ENV:  cfg.env  = i_pwdata[vdl_pkg::RGB_W-1:0];
                    default: ;
                endcase
            end
            o_pending <= color_q.size();
        end
    end

endmodule

// File: tb/tb_vertex_directional_lighting.sv
// Testbench top for vertex_directional_lighting: clock, reset, APB register setup and
// vertex stimulus in bursts; prediction and comparison live in vdl_color_checker.
`timescale 1ns / 1ps

module tb_vertex_directional_lighting;

    import vdl_pkg::*;

    localparam int         DRAIN_CYCLES  = 8;
    localparam int         STALL_LIMIT   = 1000;
    localparam int         RANDOM_PHASES = 6;
    localparam int         PHASE_ITEMS   = 122;
    localparam logic [2:0] IDX_UNUSED6   = 3'd6;
    localparam logic [2:0] IDX_UNUSED7   = 3'd7;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic [7:0]        i_vertex_r  = 8'h00;
    logic [7:0]        i_vertex_g  = 8'h00;
    logic [7:0]        i_vertex_b  = 8'h00;
    logic              i_lit_flag  = 1'b0;
    logic              i_env_flag  = 1'b0;
    logic              o_valid;
    logic [7:0]        o_out_red;
    logic [7:0]        o_out_green;
    logic [7:0]        o_out_blue;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int pending;
    int errors;
    int results;
    int stall_cnt = 0;
    int n_lit     = 0;
    int n_env     = 0;
    int n_pass    = 0;
    int n_setting = 0;

    vertex_directional_lighting uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_vertex_r  (i_vertex_r),
        .i_vertex_g  (i_vertex_g),
        .i_vertex_b  (i_vertex_b),
        .i_lit_flag  (i_lit_flag),
        .i_env_flag  (i_env_flag),
        .o_valid     (o_valid),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    vdl_color_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_vertex_r  (i_vertex_r),
        .i_vertex_g  (i_vertex_g),
        .i_vertex_b  (i_vertex_b),
        .i_lit_flag  (i_lit_flag),
        .i_env_flag  (i_env_flag),
        .i_valid     (o_valid),
        .i_out_red   (o_out_red),
        .i_out_green (o_out_green),
        .i_out_blue  (o_out_blue),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_results   (results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pwrite && pready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         stall_cnt, pending);
                $display("tb_vertex_directional_lighting NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 11))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // unit-scale directions in half of the draws; the others are extremes or random
    function automatic logic [15:0] rand_dir16();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3, 4, 5, 6, 7: return 16'(int'($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [23:0] rand_color24();
        return {rand_byte(), rand_byte(), rand_byte()};
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_vertex(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic lit, input logic env);
        start      <= 1'b1;
        i_vertex_r <= r;
        i_vertex_g <= g;
        i_vertex_b <= b;
        i_lit_flag <= lit;
        i_env_flag <= env;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (lit) n_lit++;
        else if (env) n_env++;
        else n_pass++;
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_random_setting();
        logic [DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        apb_write(REG_DIR0, {junk[63:48], rand_dir16(), rand_dir16(), rand_dir16()});
        junk = {$urandom, $urandom};
        apb_write(REG_DIR1, {junk[63:48], rand_dir16(), rand_dir16(), rand_dir16()});
        junk = {$urandom, $urandom};
        apb_write(REG_COL0, {junk[63:24], rand_color24()});
        apb_write(REG_COL1, {junk[63:24], rand_color24()});
        apb_write(REG_AMB,  {junk[63:24], ($urandom_range(0, 3) == 0) ? rand_color24()
                                                                     : 24'h101010 & rand_color24()});
        apb_write(REG_ENV,  {junk[63:24], rand_color24()});
        n_setting++;
    endtask

    task automatic run_random_phase(input int count, input bit back_to_back);
        int sent;
        int burst;
        int pause_at;
        sent     = 0;
        pause_at = $urandom_range(1, count - 1);
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < count) begin
                if (sent == pause_at) drain();
                send_vertex(rand_byte(), rand_byte(), rand_byte(),
                            $urandom_range(0, 9) < 6, 1'($urandom_range(0, 1)));
                sent++;
                burst--;
            end
            if (!back_to_back) hold_off($urandom_range(1, 10));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset values: lights dark, environment white
        n_setting++;
        send_vertex(8'h7F, 8'h7F, 8'h7F, 1'b1, 1'b0);
        send_vertex(8'h12, 8'h34, 8'h56, 1'b0, 1'b1);
        send_vertex(8'h00, 8'hFF, 8'h80, 1'b0, 1'b0);
        send_vertex(8'h80, 8'h80, 8'h80, 1'b1, 1'b1);
        drain();

        // junk above each register width, writes to unused indexes
        apb_write(REG_DIR0, {16'hDEAD, 16'h1000, 16'hF000, 16'h7FFF});
        apb_write(REG_DIR1, {16'hBEEF, 16'h8000, 16'h0800, 16'hFFFF});
        apb_write(REG_COL0, {40'hA5A5A5A5A5, 24'hFF8040});
        apb_write(REG_COL1, {40'h5A5A5A5A5A, 24'h40C0FF});
        apb_write(REG_AMB,  {40'hFFFFFFFFFF, 24'h102030});
        apb_write(REG_ENV,  {40'h0123456789, 24'h00FF00});
        apb_write(IDX_UNUSED6, '1);
        apb_write(IDX_UNUSED7, '1);
        n_setting++;
        send_vertex(8'h7F, 8'h80, 8'h01, 1'b1, 1'b0);
        send_vertex(8'h80, 8'h7F, 8'h80, 1'b1, 1'b0);
        send_vertex(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
        send_vertex(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
        send_vertex(8'h01, 8'h01, 8'h01, 1'b1, 1'b0);
        send_vertex(8'h80, 8'h80, 8'h80, 1'b1, 1'b0);
        send_vertex(8'h7F, 8'h7F, 8'h7F, 1'b1, 1'b0);
        send_vertex(8'h40, 8'hC0, 8'h20, 1'b1, 1'b0);
        send_vertex(8'hAA, 8'h55, 8'hAA, 1'b0, 1'b1);
        send_vertex(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
        send_vertex(8'h01, 8'h7F, 8'h80, 1'b1, 1'b1);
        drain();

        // full-scale directions and colors: every lit channel saturates; environment is black
        apb_write(REG_DIR0, {16'h0000, 16'h8000, 16'h8000, 16'h8000});
        apb_write(REG_DIR1, {16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        apb_write(REG_COL0, 64'hFFFFFF);
        apb_write(REG_COL1, 64'hFFFFFF);
        apb_write(REG_AMB,  64'hFFFFFF);
        apb_write(REG_ENV,  64'h000000);
        n_setting++;
        send_vertex(8'h80, 8'h80, 8'h80, 1'b1, 1'b0);
        send_vertex(8'h7F, 8'h7F, 8'h7F, 1'b1, 1'b0);
        send_vertex(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
        send_vertex(8'h33, 8'h66, 8'h99, 1'b0, 1'b1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_random_setting();
            run_random_phase(PHASE_ITEMS, p == 2);
            drain();
        end

        $display("covered %0d vertices (%0d lit, %0d environment, %0d pass-through)",
                 n_lit + n_env + n_pass, n_lit, n_env, n_pass);
        $display("over %0d register settings, %0d results checked, %0d mismatches",
                 n_setting, results, errors);
        if (errors == 0 && pending == 0) begin
            $display("tb_vertex_directional_lighting OK");
        end else begin
            $display("tb_vertex_directional_lighting NOT OK");
        end
        $finish;
    end

endmodule
